>>> rtl/mdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdw_pkg: shared definitions of the deadline watchdog
// action and status codes, field widths and the controller/datapath links
// ----------------------------------------------------------------------------
package mdw_pkg;

  // default table size
  localparam int NUM_SLOTS_DEF = 16;

  // field widths
  localparam int ACTION_W = 2;
  localparam int DELAY_W  = 16;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int TIME_W   = 32;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input word and clear scan accumulators
    logic apply;   // tick the clock or free a slot
    logic scan;    // visit one slot
    logic finish;  // arm a submitted slot and register the result
  } mdw_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // the slot being visited is the last one
  } mdw_stat_t;

endpackage

>>> rtl/mdw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdw_ctrl: item sequencer
// steps each word through apply, slot scan, drain and finish
// ----------------------------------------------------------------------------
module mdw_ctrl
  import mdw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  mdw_stat_t stat,
  output mdw_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.apply  = (state == S_APPLY);
    cmd.scan   = (state == S_SCAN);
    cmd.finish = (state == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          busy  <= 1'b0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/mdw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdw_datapath: clock, deadline table and scan
// seconds counter, deadline memory, armed bits, scan accumulators, result
// ----------------------------------------------------------------------------
module mdw_datapath
  import mdw_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mdw_cmd_t            cmd,
  output mdw_stat_t           stat,
  input  logic [ACTION_W-1:0] action,
  input  logic [DELAY_W-1:0]  delay_seconds,
  input  logic [HANDLE_W-1:0] slot_handle,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   assigned_slot,
  output logic [COUNT_W-1:0]  active_count,
  output logic                expired
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // captured word
  logic [ACTION_W-1:0] act_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [STATUS_W-1:0] status_q;

  logic [TIME_W-1:0]    now_seconds;
  logic [TIME_W-1:0]    slot_deadline [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_active;

  // scan state
  logic [IDX_W-1:0]  scan_idx;
  logic              s1_valid;
  logic              s1_active;
  logic [TIME_W-1:0] rd_data;
  logic [CNT_W-1:0]  cnt;
  logic              due;
  logic              found;
  logic [IDX_W-1:0]  free_idx;

  logic              handle_ok;
  logic [IDX_W-1:0]  handle_idx;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] new_deadline;

  assign handle_ok      = 32'(handle_q) < NUM_SLOTS;
  assign handle_idx     = IDX_W'(handle_q);
  assign diff           = now_seconds - rd_data;
  assign new_deadline   = now_seconds + TIME_W'(delay_q);
  assign stat.scan_last = (scan_idx == IDX_W'(NUM_SLOTS - 1));

  // deadline memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= slot_deadline[scan_idx];
    end
    if (cmd.finish && (act_q == ACT_SUBMIT) && found) begin
      slot_deadline[free_idx] <= new_deadline;
    end
  end

  // word capture and scan accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      scan_idx <= '0;
      found    <= 1'b0;
      due      <= 1'b0;
      cnt      <= '0;
    end else begin
      s1_valid <= cmd.scan;
      if (cmd.load) begin
        act_q    <= action;
        delay_q  <= delay_seconds;
        handle_q <= slot_handle;
        scan_idx <= '0;
        found    <= 1'b0;
        due      <= 1'b0;
        cnt      <= '0;
        free_idx <= '0;
      end
      if (cmd.scan) begin
        s1_active <= slot_active[scan_idx];
        scan_idx  <= scan_idx + IDX_W'(1);
        if (!found && !slot_active[scan_idx]) begin
          found    <= 1'b1;
          free_idx <= scan_idx;
        end
      end
      // deadline of the previous slot arrives in the cycle after its read
      if (s1_valid && s1_active) begin
        cnt <= cnt + CNT_W'(1);
        if (!diff[TIME_W-1]) begin
          due <= 1'b1;
        end
      end
    end
  end

  // clock, armed bits, sticky latch and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      slot_active <= '0;
      expired     <= 1'b0;
    end else begin
      if (cmd.load) begin
        status_q <= ST_OK;
      end
      if (cmd.apply) begin
        if (act_q == ACT_TICK) begin
          now_seconds <= now_seconds + TIME_W'(1);
        end else if (act_q == ACT_CLEAR) begin
          if (handle_ok && slot_active[handle_idx]) begin
            slot_active[handle_idx] <= 1'b0;
          end else begin
            status_q <= ST_NOT_ACTIVE;
          end
        end
      end
      if (cmd.finish) begin
        if ((act_q == ACT_SUBMIT) && found) begin
          slot_active[free_idx] <= 1'b1;
          status        <= ST_OK;
          assigned_slot <= SLOT_W'(free_idx);
          active_count  <= COUNT_W'(cnt + CNT_W'(1));
          // a zero delay is due at once
          expired       <= expired | due | (delay_q == '0);
        end else begin
          status        <= (act_q == ACT_SUBMIT) ? ST_FULL : status_q;
          assigned_slot <= '0;
          active_count  <= COUNT_W'(cnt);
          expired       <= expired | due;
        end
      end
    end
  end

endmodule

>>> rtl/multi_deadline_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_deadline_watchdog: multi-slot deadline watchdog
// seconds counter plus a table of armed deadlines with a sticky expiry flag
// ----------------------------------------------------------------------------
//
//  channel  handshake            ports
//  -------  -------------------  ------------------------------------------
//  input    start & !busy        action, delay_seconds, slot_handle
//  result   done (one cycle)     status, assigned_slot, active_count, expired
//
//  a word passes from accept to done through the apply state, the scan state,
//  which visits the slots in turn through the single read port of the
//  deadline memory, the drain state for the registered read and the finish
//  state. a new word may be accepted in the cycle that done is high.
//  rst is synchronous; it zeroes the seconds counter, the armed bits and the
//  expired flag. the deadline memory is not cleared, only armed slots are used.
//  the receiver cannot stall: each result is valid for the single done cycle.
//
module multi_deadline_watchdog
  import mdw_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input word
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [DELAY_W-1:0]  delay_seconds,
  input  logic [HANDLE_W-1:0] slot_handle,
  // result word
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   assigned_slot,
  output logic [COUNT_W-1:0]  active_count,
  output logic                expired
);

  mdw_cmd_t  cmd;
  mdw_stat_t stat;

  // sequencer: idle, apply, scan, drain, finish
  mdw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // counter, deadline table, scan and result registers
  mdw_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .delay_seconds (delay_seconds),
    .slot_handle   (slot_handle),
    .status        (status),
    .assigned_slot (assigned_slot),
    .active_count  (active_count),
    .expired       (expired)
  );

endmodule
